FILE: rtl/sscc_pkg.sv
// Shared types, constants and next-state functions for the stepper sweep cycle controller.
// No dependencies.

package sscc_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STEPS_W  = 16;
  localparam int unsigned DWELL_W  = 8;
  localparam int unsigned TIMER_W  = 18;
  localparam int unsigned COUNT_W  = 32;
  // dwell product must hold both the largest product and the timer limit
  localparam int unsigned PROD_BITS = DWELL_W + $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned PROD_W    = (PROD_BITS > TIMER_W) ? PROD_BITS : TIMER_W + 1;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_SWEEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_SECONDS   = 2'd2;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST     = 16'd10;
  localparam logic [STEPS_W-1:0]  STEPS_PER_SWEEP_RST = 16'd200;
  localparam logic [DWELL_W-1:0]  DWELL_SECONDS_RST   = 8'd1;

  localparam logic [PROD_W-1:0] DWELL_LIMIT = PROD_W'(2 ** TIMER_W);

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_FWD       = 3'd1,
    MODE_DWELL1    = 3'd2,
    MODE_REV       = 3'd3,
    MODE_DWELL2    = 3'd4,
    MODE_FWD_ABORT = 3'd5,
    MODE_REV_ABORT = 3'd6
  } mode_t;

  // drive[0] enable_a, drive[1] enable_b, drive[2] dir_a, drive[3] dir_b
  typedef struct packed {
    mode_t              mode;
    logic [1:0]         phase;
    logic [STEPS_W-1:0] steps_left;
    logic [TIMER_W-1:0] timer;
    logic [COUNT_W-1:0] sweeps;
    logic [3:0]         drive;
  } seq_state_t;

  // configuration in the form the sequencer uses it
  typedef struct packed {
    logic [STEPS_W-1:0] steps_per_sweep;
    logic [TIMER_W-1:0] step_wait;
    logic [TIMER_W-1:0] dwell_wait;
    logic               dwell_zero;
  } seq_cfg_t;

  typedef struct packed {
    logic               busy_res;
    logic [COUNT_W-1:0] cycle_count;
    logic               dir_b;
    logic               dir_a;
    logic               enable_b;
    logic               enable_a;
  } result_t;

  function automatic seq_state_t issue_step(seq_state_t s, logic rev, seq_cfg_t c);
    seq_state_t n;
    n = s;
    unique case (s.phase)
      2'd0: n.drive = {s.drive[3], 1'b1, 1'b0, 1'b1};
      2'd1: n.drive = {~rev, s.drive[2], 1'b1, 1'b0};
      2'd2: n.drive = {s.drive[3], 1'b0, 1'b0, 1'b1};
      default: n.drive = {rev, s.drive[2], 1'b1, 1'b0};
    endcase
    n.phase = s.phase + 2'd1;
    n.timer = c.step_wait;
    return n;
  endfunction

  function automatic seq_state_t end_rev(seq_state_t s, seq_cfg_t c);
    seq_state_t n;
    n = s;
    n.sweeps = s.sweeps + COUNT_W'(1);
    if (c.dwell_zero) begin
      n.mode = MODE_IDLE;
    end else begin
      n.timer = c.dwell_wait;
      n.mode  = MODE_DWELL2;
    end
    return n;
  endfunction

  function automatic seq_state_t begin_rev(seq_state_t s, seq_cfg_t c);
    seq_state_t n;
    n = s;
    n.steps_left = c.steps_per_sweep;
    if (c.steps_per_sweep == '0) begin
      n = end_rev(n, c);
    end else begin
      n = issue_step(n, 1'b1, c);
      n.steps_left = c.steps_per_sweep - STEPS_W'(1);
      n.mode = MODE_REV;
    end
    return n;
  endfunction

  function automatic seq_state_t end_fwd(seq_state_t s, seq_cfg_t c);
    seq_state_t n;
    n = s;
    n.sweeps = s.sweeps + COUNT_W'(1);
    if (c.dwell_zero) begin
      n = begin_rev(n, c);
    end else begin
      n.timer = c.dwell_wait;
      n.mode  = MODE_DWELL1;
    end
    return n;
  endfunction

  function automatic seq_state_t begin_fwd(seq_state_t s, seq_cfg_t c);
    seq_state_t n;
    n = s;
    n.steps_left = c.steps_per_sweep;
    if (c.steps_per_sweep == '0) begin
      n = end_fwd(n, c);
    end else begin
      n = issue_step(n, 1'b0, c);
      n.steps_left = c.steps_per_sweep - STEPS_W'(1);
      n.mode = MODE_FWD;
    end
    return n;
  endfunction

endpackage

FILE: rtl/sscc_seq.sv
// Sweep sequencer: run state, phase, step and dwell timers, sweep counter.
// Depends on sscc_pkg.

module sscc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic                          start_req,
  input  logic                          abort,
  input  logic [sscc_pkg::PERIOD_W-1:0] step_period,
  input  logic [sscc_pkg::STEPS_W-1:0]  steps_per_sweep,
  input  logic [sscc_pkg::DWELL_W-1:0]  dwell_seconds,
  output sscc_pkg::result_t             result
);

  sscc_pkg::seq_state_t state;
  sscc_pkg::seq_state_t state_next;
  sscc_pkg::seq_cfg_t   cfg;
  logic [sscc_pkg::PROD_W-1:0] dwell_ticks;
  logic                        rev;
  logic                        aborting;

  // dwell length in ticks, clamped to the timer range
  always_comb begin
    dwell_ticks = sscc_pkg::PROD_W'(dwell_seconds)
                * sscc_pkg::PROD_W'(sscc_pkg::TICKS_PER_SECOND);
    cfg.steps_per_sweep = steps_per_sweep;
    cfg.step_wait = (step_period == '0) ? '0
                  : sscc_pkg::TIMER_W'(step_period - sscc_pkg::PERIOD_W'(1));
    cfg.dwell_zero = (dwell_seconds == '0);
    if (dwell_ticks >= sscc_pkg::DWELL_LIMIT) begin
      cfg.dwell_wait = '1;
    end else begin
      cfg.dwell_wait = sscc_pkg::TIMER_W'(dwell_ticks - sscc_pkg::PROD_W'(1));
    end
  end

  assign rev      = (state.mode == sscc_pkg::MODE_REV) ||
                    (state.mode == sscc_pkg::MODE_REV_ABORT);
  assign aborting = (state.mode == sscc_pkg::MODE_FWD_ABORT) ||
                    (state.mode == sscc_pkg::MODE_REV_ABORT);

  always_comb begin
    state_next = state;
    unique case (state.mode)
      sscc_pkg::MODE_IDLE: begin
        if (start_req) begin
          state_next = sscc_pkg::begin_fwd(state, cfg);
        end
      end
      sscc_pkg::MODE_FWD, sscc_pkg::MODE_REV,
      sscc_pkg::MODE_FWD_ABORT, sscc_pkg::MODE_REV_ABORT: begin
        priority if (state.timer != '0) begin
          state_next.timer = state.timer - sscc_pkg::TIMER_W'(1);
          if (abort) begin
            state_next.mode = rev ? sscc_pkg::MODE_REV_ABORT : sscc_pkg::MODE_FWD_ABORT;
          end
        end else if (abort || aborting) begin
          state_next.mode = sscc_pkg::MODE_IDLE;
        end else if (state.steps_left != '0) begin
          state_next = sscc_pkg::issue_step(state, rev, cfg);
          state_next.steps_left = state.steps_left - sscc_pkg::STEPS_W'(1);
        end else if (rev) begin
          state_next = sscc_pkg::end_rev(state, cfg);
        end else begin
          state_next = sscc_pkg::end_fwd(state, cfg);
        end
      end
      sscc_pkg::MODE_DWELL1: begin
        if (state.timer != '0) begin
          state_next.timer = state.timer - sscc_pkg::TIMER_W'(1);
        end else begin
          state_next = sscc_pkg::begin_rev(state, cfg);
        end
      end
      sscc_pkg::MODE_DWELL2: begin
        if (state.timer != '0) begin
          state_next.timer = state.timer - sscc_pkg::TIMER_W'(1);
        end else begin
          state_next.mode = sscc_pkg::MODE_IDLE;
        end
      end
      default: state_next.mode = sscc_pkg::MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= sscc_pkg::MODE_IDLE;
      state.phase      <= '0;
      state.steps_left <= '0;
      state.timer      <= '0;
      state.sweeps     <= '0;
      state.drive      <= '0;
    end else if (tick) begin
      state <= state_next;
    end
  end

  // result shows the state after this tick
  assign result.enable_a    = state_next.drive[0];
  assign result.enable_b    = state_next.drive[1];
  assign result.dir_a       = state_next.drive[2];
  assign result.dir_b       = state_next.drive[3];
  assign result.cycle_count = state_next.sweeps;
  assign result.busy_res    = (state_next.mode != sscc_pkg::MODE_IDLE);

endmodule

FILE: rtl/sscc_skid.sv
// Output register with one skid entry for the result stream.
// Depends on sscc_pkg.

module sscc_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sscc_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sscc_pkg::result_t out_data
);

  logic              skid_valid;
  sscc_pkg::result_t skid_data;
  logic              in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
        out_data  <= in_data;
      end
    end else if (in_fire) begin
      // output stalled: park the new transaction
      skid_valid <= 1'b1;
      skid_data  <= in_data;
    end
  end

endmodule

FILE: rtl/stepper_sweep_cycle_controller_top.sv
// Stepper sweep cycle controller: one tick transaction in, one drive/status result out.
// Ticks are accepted at one per cycle while the skid entry is empty; the result is registered onto m_tvalid.
// A single skid entry lets a tick be taken while the output is stalled.
// Reset (rst, synchronous): idle, phase 0, counters cleared, both channels braked,
// registers to step_period 10, steps_per_sweep 200, dwell_seconds 1.
// Depends on sscc_pkg, sscc_seq, sscc_skid.

module stepper_sweep_cycle_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sscc_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] start_req, [1] abort
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sscc_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] enable_a, [1] enable_b, [2] dir_a,
                                                      // [3] dir_b, [35:4] cycle_count,
                                                      // [36] busy_res
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sscc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [sscc_pkg::PERIOD_W-1:0] step_period;
  logic [sscc_pkg::STEPS_W-1:0]  steps_per_sweep;
  logic [sscc_pkg::DWELL_W-1:0]  dwell_seconds;
  logic                          tick;
  sscc_pkg::result_t             seq_result;
  sscc_pkg::result_t             out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period     <= sscc_pkg::STEP_PERIOD_RST;
      steps_per_sweep <= sscc_pkg::STEPS_PER_SWEEP_RST;
      dwell_seconds   <= sscc_pkg::DWELL_SECONDS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sscc_pkg::REG_STEP_PERIOD:     step_period     <= cfg_data;
        sscc_pkg::REG_STEPS_PER_SWEEP: steps_per_sweep <= cfg_data;
        sscc_pkg::REG_DWELL_SECONDS:
          dwell_seconds <= cfg_data[sscc_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick = s_tvalid && s_tready;

  sscc_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .start_req       (s_tdata[0]),
    .abort           (s_tdata[1]),
    .step_period     (step_period),
    .steps_per_sweep (steps_per_sweep),
    .dwell_seconds   (dwell_seconds),
    .result          (seq_result)
  );

  sscc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (seq_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {3'b000, out_result.busy_res, out_result.cycle_count,
                    out_result.dir_b, out_result.dir_a,
                    out_result.enable_b, out_result.enable_a};

endmodule
